[design/wsfp_pkg.sv]
// Package with the shared types, codes and constants of the wheel speed feedback poller.
`timescale 1ns / 1ps

package wsfp_pkg;

  localparam int ADDR_W = 3;

  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_RESP    = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;
  localparam logic [1:0] REQ_BUS     = 2'd3;

  localparam logic CFG_NODE_ID = 1'b0;
  localparam logic CFG_PERIOD  = 1'b1;

  localparam logic [15:0] BASE_INDEX = 16'h4000;
  localparam logic [15:0] REG_R_HIGH = 16'h0009;
  localparam logic [15:0] REG_R_LOW  = 16'h000A;
  localparam logic [15:0] REG_L_HIGH = 16'h0014;
  localparam logic [15:0] REG_L_LOW  = 16'h0015;

  localparam logic [15:0] IDX_R_HIGH = BASE_INDEX + REG_R_HIGH;
  localparam logic [15:0] IDX_R_LOW  = BASE_INDEX + REG_R_LOW;
  localparam logic [15:0] IDX_L_HIGH = BASE_INDEX + REG_L_HIGH;
  localparam logic [15:0] IDX_L_LOW  = BASE_INDEX + REG_L_LOW;

  localparam logic [7:0]  PERIOD_RESET = 8'd5;
  localparam logic [3:0]  MIN_DLC      = 4'd6;
  localparam logic [1:0]  BOTH_WORDS   = 2'b11;
  localparam logic [1:0]  MASK_HIGH    = 2'b01;
  localparam logic [1:0]  MASK_LOW     = 2'b10;
  localparam logic [31:0] NONE_AGE     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic [15:0] resp_index;
    logic [15:0] resp_word;
    logic [3:0]  resp_dlc;
    logic        queue_ready;
    logic [15:0] recov_count;
    logic        bus_trouble;
    logic        read_in_flight;
  } item_t;

  typedef struct packed {
    logic               issue_query;
    logic [15:0]        query_index;
    logic [10:0]        query_node;
    logic signed [31:0] right_wheel_rpm;
    logic signed [31:0] left_wheel_rpm;
    logic               right_live;
    logic               left_live;
    logic [31:0]        right_age;
    logic [31:0]        left_age;
    logic               fault_on;
    logic [31:0]        timeout_count;
    logic [31:0]        last_ok_age_ms;
  } result_t;

  typedef struct packed {
    logic [10:0] node_id;
    logic [7:0]  query_period_ms;
  } cfg_t;

  function automatic logic [15:0] slot_index(input logic [1:0] slot);
    logic [15:0] idx;
    case (slot)
      2'd0: idx = IDX_R_HIGH;
      2'd1: idx = IDX_R_LOW;
      2'd2: idx = IDX_L_HIGH;
      default: idx = IDX_L_LOW;
    endcase
    return idx;
  endfunction

endpackage

[design/wsfp_cfg.sv]
// Configuration register file of the poller, written and read over the APB-style port.
`timescale 1ns / 1ps

module wsfp_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wsfp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output wsfp_pkg::cfg_t             cfg
);

  logic [10:0] node_id;
  logic [7:0]  query_period_ms;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id         <= '0;
      query_period_ms <= wsfp_pkg::PERIOD_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        wsfp_pkg::CFG_NODE_ID: node_id <= pwdata[10:0];
        wsfp_pkg::CFG_PERIOD:  query_period_ms <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      wsfp_pkg::CFG_NODE_ID: prdata = {21'd0, node_id};
      wsfp_pkg::CFG_PERIOD:  prdata = {24'd0, query_period_ms};
      default: prdata = '0;
    endcase
  end

  assign cfg.node_id         = node_id;
  assign cfg.query_period_ms = query_period_ms;

endmodule

[design/wsfp_core.sv]
// Poller state registers and the single-pass event logic that forms one result beat.
`timescale 1ns / 1ps

module wsfp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  wsfp_pkg::item_t   item,
  input  wsfp_pkg::cfg_t    cfg,
  output wsfp_pkg::result_t res
);

  logic [15:0] right_high_word, right_low_word, left_high_word, left_low_word;
  logic [1:0]  right_word_mask, left_word_mask;
  logic [31:0] right_speed, left_speed, right_stamp, left_stamp;
  logic [31:0] last_query_stamp, last_ok_stamp, timeouts_seen;
  logic [15:0] seen_recovery;
  logic [1:0]  next_slot;
  logic        rd_busy, fault_flag;

  logic [15:0] right_high_word_next, right_low_word_next;
  logic [15:0] left_high_word_next, left_low_word_next;
  logic [1:0]  right_word_mask_next, left_word_mask_next;
  logic [31:0] right_speed_next, left_speed_next, right_stamp_next, left_stamp_next;
  logic [31:0] last_query_stamp_next, last_ok_stamp_next, timeouts_seen_next;
  logic [15:0] seen_recovery_next;
  logic [1:0]  next_slot_next;
  logic        rd_busy_next, fault_flag_next;

  logic [31:0] since_query;
  logic        hold_off;
  logic        issue;
  logic        hit_rh, hit_rl, hit_lh, hit_ll, hit_any;
  logic        r_live, l_live;

  assign since_query = item.now_ms - last_query_stamp;
  assign hold_off    = (last_query_stamp != '0) && (since_query < {24'd0, cfg.query_period_ms});
  assign issue       = (item.req_type == wsfp_pkg::REQ_TICK) && !rd_busy && !hold_off
                       && item.queue_ready;

  assign hit_rh  = item.resp_index == wsfp_pkg::IDX_R_HIGH;
  assign hit_rl  = item.resp_index == wsfp_pkg::IDX_R_LOW;
  assign hit_lh  = item.resp_index == wsfp_pkg::IDX_L_HIGH;
  assign hit_ll  = item.resp_index == wsfp_pkg::IDX_L_LOW;
  assign hit_any = (hit_rh || hit_rl || hit_lh || hit_ll) && (item.resp_dlc >= wsfp_pkg::MIN_DLC);

  always_comb begin
    right_high_word_next  = right_high_word;
    right_low_word_next   = right_low_word;
    left_high_word_next   = left_high_word;
    left_low_word_next    = left_low_word;
    right_word_mask_next  = right_word_mask;
    left_word_mask_next   = left_word_mask;
    right_speed_next      = right_speed;
    left_speed_next       = left_speed;
    right_stamp_next      = right_stamp;
    left_stamp_next       = left_stamp;
    last_query_stamp_next = last_query_stamp;
    last_ok_stamp_next    = last_ok_stamp;
    timeouts_seen_next    = timeouts_seen;
    seen_recovery_next    = seen_recovery;
    next_slot_next        = next_slot;
    rd_busy_next          = rd_busy;
    fault_flag_next       = fault_flag;

    case (item.req_type)
      wsfp_pkg::REQ_TICK: begin
        if (issue) begin
          rd_busy_next          = 1'b1;
          last_query_stamp_next = item.now_ms;
          next_slot_next        = next_slot + 2'd1;
        end
      end
      wsfp_pkg::REQ_RESP: begin
        if (hit_any) begin
          if (hit_rh) begin
            right_high_word_next = item.resp_word;
            right_word_mask_next = right_word_mask | wsfp_pkg::MASK_HIGH;
          end else if (hit_rl) begin
            right_low_word_next  = item.resp_word;
            right_word_mask_next = right_word_mask | wsfp_pkg::MASK_LOW;
          end else if (hit_lh) begin
            left_high_word_next = item.resp_word;
            left_word_mask_next = left_word_mask | wsfp_pkg::MASK_HIGH;
          end else begin
            left_low_word_next  = item.resp_word;
            left_word_mask_next = left_word_mask | wsfp_pkg::MASK_LOW;
          end
          rd_busy_next       = 1'b0;
          last_ok_stamp_next = item.now_ms;
          if (right_word_mask_next == wsfp_pkg::BOTH_WORDS) begin
            right_speed_next = {right_high_word_next, right_low_word_next};
            right_stamp_next = item.now_ms;
          end
          if (left_word_mask_next == wsfp_pkg::BOTH_WORDS) begin
            left_speed_next = {left_high_word_next, left_low_word_next};
            left_stamp_next = item.now_ms;
          end
          if (right_word_mask_next == wsfp_pkg::BOTH_WORDS &&
              left_word_mask_next == wsfp_pkg::BOTH_WORDS) begin
            fault_flag_next = 1'b0;
          end
        end
      end
      wsfp_pkg::REQ_TIMEOUT: begin
        rd_busy_next         = 1'b0;
        fault_flag_next      = 1'b1;
        timeouts_seen_next   = timeouts_seen + 32'd1;
        right_high_word_next = '0;
        right_low_word_next  = '0;
        left_high_word_next  = '0;
        left_low_word_next   = '0;
        right_word_mask_next = '0;
        left_word_mask_next  = '0;
        right_speed_next     = '0;
        left_speed_next      = '0;
        right_stamp_next     = '0;
        left_stamp_next      = '0;
      end
      default: begin
        if (item.recov_count != seen_recovery) begin
          seen_recovery_next   = item.recov_count;
          rd_busy_next         = 1'b0;
          fault_flag_next      = 1'b1;
          next_slot_next       = '0;
          right_high_word_next = '0;
          right_low_word_next  = '0;
          left_high_word_next  = '0;
          left_low_word_next   = '0;
          right_word_mask_next = '0;
          left_word_mask_next  = '0;
          right_speed_next     = '0;
          left_speed_next      = '0;
          right_stamp_next     = '0;
          left_stamp_next      = '0;
        end
        if (item.bus_trouble && !item.read_in_flight) begin
          rd_busy_next = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_high_word  <= '0;
      right_low_word   <= '0;
      left_high_word   <= '0;
      left_low_word    <= '0;
      right_word_mask  <= '0;
      left_word_mask   <= '0;
      right_speed      <= '0;
      left_speed       <= '0;
      right_stamp      <= '0;
      left_stamp       <= '0;
      last_query_stamp <= '0;
      last_ok_stamp    <= '0;
      timeouts_seen    <= '0;
      seen_recovery    <= '0;
      next_slot        <= '0;
      rd_busy          <= 1'b0;
      fault_flag       <= 1'b0;
    end else if (fire) begin
      right_high_word  <= right_high_word_next;
      right_low_word   <= right_low_word_next;
      left_high_word   <= left_high_word_next;
      left_low_word    <= left_low_word_next;
      right_word_mask  <= right_word_mask_next;
      left_word_mask   <= left_word_mask_next;
      right_speed      <= right_speed_next;
      left_speed       <= left_speed_next;
      right_stamp      <= right_stamp_next;
      left_stamp       <= left_stamp_next;
      last_query_stamp <= last_query_stamp_next;
      last_ok_stamp    <= last_ok_stamp_next;
      timeouts_seen    <= timeouts_seen_next;
      seen_recovery    <= seen_recovery_next;
      next_slot        <= next_slot_next;
      rd_busy          <= rd_busy_next;
      fault_flag       <= fault_flag_next;
    end
  end

  assign r_live = right_stamp_next != '0;
  assign l_live = left_stamp_next != '0;

  always_comb begin
    res.issue_query     = issue;
    res.query_index     = issue ? wsfp_pkg::slot_index(next_slot) : '0;
    res.query_node      = issue ? cfg.node_id : '0;
    res.right_wheel_rpm = right_speed_next;
    res.left_wheel_rpm  = left_speed_next;
    res.right_live      = r_live;
    res.left_live       = l_live;
    res.right_age       = r_live ? item.now_ms - right_stamp_next : '0;
    res.left_age        = l_live ? item.now_ms - left_stamp_next : '0;
    res.fault_on        = fault_flag_next;
    res.timeout_count   = timeouts_seen_next;
    res.last_ok_age_ms  = (last_ok_stamp_next == '0) ? wsfp_pkg::NONE_AGE
                                                     : item.now_ms - last_ok_stamp_next;
  end

  assert property (@(posedge clk) disable iff (rst)
    fire && res.issue_query |=> rd_busy)
    else $error("A read was issued but no read is marked pending.");

  assert property (@(posedge clk) disable iff (rst)
    fire && item.req_type == wsfp_pkg::REQ_TIMEOUT |=>
      timeouts_seen == $past(timeouts_seen) + 32'd1 && right_word_mask == '0 &&
      left_word_mask == '0 && !rd_busy && fault_flag)
    else $error("A timeout did not count, clear the cache and raise the fault.");

  assert property (@(posedge clk) disable iff (rst)
    $fell(fault_flag) |-> $past(rst) || $past(fire && item.req_type == wsfp_pkg::REQ_RESP))
    else $error("The fault flag cleared on an event other than a response.");

  assert property (@(posedge clk) disable iff (rst)
    fire && item.req_type != wsfp_pkg::REQ_TICK |-> !res.issue_query && res.query_index == '0)
    else $error("A read was issued on an event that is not a tick.");

endmodule

[design/wheel_speed_feedback_poller.sv]
// Top level of the wheel speed feedback poller: input register, event logic and result register.
`timescale 1ns / 1ps

// Usage:
// Each event beat on the item channel (item_valid/item_ready) yields exactly one result
// beat on the result channel (result_valid/result_ready), in order. A tick may issue a
// read of the next speed register, a response fills the word cache and assembles rpm,
// a timeout or a changed bus recovery count raises the fault flag and clears the cache.
// An accepted beat lands in the input register; the event logic between that register
// and the result register updates the poller state and forms the result, which is
// offered once it is registered in the result register. One beat per cycle is sustained
// when the receiver keeps result_ready high; the state loop closes through the event logic.
// When the receiver stalls, the result register holds its beat, the input register
// keeps at most one more, and item_ready drops until the result is taken.
// The configuration port writes node_id at byte address 0 and query_period_ms at
// address 4; write only while no beat is in flight. Synchronous reset clears all state,
// empties both registers, sets node_id to 0 and query_period_ms to 5.
module wheel_speed_feedback_poller (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  wsfp_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output wsfp_pkg::result_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wsfp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  wsfp_pkg::cfg_t    cfg;
  wsfp_pkg::item_t   stage_item;
  wsfp_pkg::result_t core_res;
  logic              stage_valid;
  logic              advance;

  assign advance    = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_res;
    end
  end

  wsfp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wsfp_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (stage_item),
    .cfg  (cfg),
    .res  (core_res)
  );

endmodule

[dv/tb_wheel_speed_feedback_poller.sv]
// Testbench of the wheel speed feedback poller: directed table, random event phases, scoreboard.
`timescale 1ns / 1ps

module tb_wheel_speed_feedback_poller;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRINT_CAP = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  wsfp_pkg::item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  wsfp_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [wsfp_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  wheel_speed_feedback_poller dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  typedef struct {
    wsfp_pkg::item_t   e;
    bit                typed;
    wsfp_pkg::result_t want;
  } row_t;

  // Poller state as the scoreboard sees it.
  logic [15:0] rh_word, rl_word, lh_word, ll_word;
  logic [1:0]  r_mask, l_mask;
  logic [31:0] r_speed, l_speed, r_stamp, l_stamp;
  logic [31:0] query_stamp, ok_stamp, timeouts;
  logic [15:0] recov_seen;
  logic [1:0]  slot;
  logic        pending, fault;
  logic [15:0] asked_index;
  logic [10:0] node_cfg;
  logic [7:0]  period_cfg;

  wsfp_pkg::result_t speed_results[$];
  bit      item_typed = 1'b0;
  wsfp_pkg::result_t item_typed_res = '0;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  logic [31:0] clock_ms = '0;
  logic [15:0] link_recoveries = '0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  function automatic void wipe_speeds();
    rh_word = '0; rl_word = '0; lh_word = '0; ll_word = '0;
    r_mask = '0; l_mask = '0;
    r_speed = '0; l_speed = '0; r_stamp = '0; l_stamp = '0;
  endfunction

  function automatic wsfp_pkg::result_t poll_event(input wsfp_pkg::item_t e);
    wsfp_pkg::result_t r;
    logic [31:0] since;
    bit hit;
    r = '0;
    hit = 1'b1;
    case (e.req_type)
      wsfp_pkg::REQ_TICK: begin
        since = e.now_ms - query_stamp;
        if (!pending && e.queue_ready && (query_stamp == '0 || since >= {24'd0, period_cfg})) begin
          case (slot)
            2'd0: asked_index = wsfp_pkg::IDX_R_HIGH;
            2'd1: asked_index = wsfp_pkg::IDX_R_LOW;
            2'd2: asked_index = wsfp_pkg::IDX_L_HIGH;
            default: asked_index = wsfp_pkg::IDX_L_LOW;
          endcase
          r.issue_query = 1'b1;
          r.query_index = asked_index;
          r.query_node = node_cfg;
          pending = 1'b1;
          query_stamp = e.now_ms;
          slot = slot + 2'd1;
        end
      end
      wsfp_pkg::REQ_RESP: begin
        if (e.resp_dlc >= wsfp_pkg::MIN_DLC) begin
          case (e.resp_index)
            wsfp_pkg::IDX_R_HIGH: begin
              rh_word = e.resp_word; r_mask |= wsfp_pkg::MASK_HIGH;
            end
            wsfp_pkg::IDX_R_LOW: begin
              rl_word = e.resp_word; r_mask |= wsfp_pkg::MASK_LOW;
            end
            wsfp_pkg::IDX_L_HIGH: begin
              lh_word = e.resp_word; l_mask |= wsfp_pkg::MASK_HIGH;
            end
            wsfp_pkg::IDX_L_LOW: begin
              ll_word = e.resp_word; l_mask |= wsfp_pkg::MASK_LOW;
            end
            default: hit = 1'b0;
          endcase
          if (hit) begin
            pending = 1'b0;
            ok_stamp = e.now_ms;
            if (r_mask == wsfp_pkg::BOTH_WORDS) begin
              r_speed = {rh_word, rl_word};
              r_stamp = e.now_ms;
            end
            if (l_mask == wsfp_pkg::BOTH_WORDS) begin
              l_speed = {lh_word, ll_word};
              l_stamp = e.now_ms;
            end
            if (r_mask == wsfp_pkg::BOTH_WORDS && l_mask == wsfp_pkg::BOTH_WORDS) fault = 1'b0;
          end
        end
      end
      wsfp_pkg::REQ_TIMEOUT: begin
        pending = 1'b0;
        fault = 1'b1;
        timeouts = timeouts + 32'd1;
        wipe_speeds();
      end
      default: begin
        if (e.recov_count != recov_seen) begin
          recov_seen = e.recov_count;
          pending = 1'b0;
          fault = 1'b1;
          slot = 2'd0;
          wipe_speeds();
        end
        if (e.bus_trouble && !e.read_in_flight) pending = 1'b0;
      end
    endcase
    r.right_wheel_rpm = r_speed;
    r.left_wheel_rpm = l_speed;
    r.right_live = r_stamp != '0;
    r.left_live = l_stamp != '0;
    r.right_age = r.right_live ? e.now_ms - r_stamp : '0;
    r.left_age = r.left_live ? e.now_ms - l_stamp : '0;
    r.fault_on = fault;
    r.timeout_count = timeouts;
    r.last_ok_age_ms = (ok_stamp == '0) ? wsfp_pkg::NONE_AGE : e.now_ms - ok_stamp;
    return r;
  endfunction

  function automatic wsfp_pkg::item_t make_event(input logic [1:0] kind,
                                                 input logic [31:0] now,
                                                 input logic [15:0] idx,
                                                 input logic [15:0] word,
                                                 input logic [3:0] dlc, input logic qready,
                                                 input logic [15:0] rcount,
                                                 input logic trouble,
                                                 input logic inflight);
    wsfp_pkg::item_t e;
    e.req_type = kind;
    e.now_ms = now;
    e.resp_index = idx;
    e.resp_word = word;
    e.resp_dlc = dlc;
    e.queue_ready = qready;
    e.recov_count = rcount;
    e.bus_trouble = trouble;
    e.read_in_flight = inflight;
    return e;
  endfunction

  // Result with both wheels empty, as seen after reset or a cache wipe.
  function automatic wsfp_pkg::result_t no_speed_result(input logic issue,
                                                        input logic [15:0] idx,
                                                        input logic [10:0] node,
                                                        input logic flt,
                                                        input logic [31:0] tmo,
                                                        input logic [31:0] ok_age);
    wsfp_pkg::result_t r;
    r = '0;
    r.issue_query = issue;
    r.query_index = idx;
    r.query_node = node;
    r.fault_on = flt;
    r.timeout_count = tmo;
    r.last_ok_age_ms = ok_age;
    return r;
  endfunction

  always @(posedge clk) begin
    wsfp_pkg::result_t want;
    if (rst) begin
      rh_word = '0; rl_word = '0; lh_word = '0; ll_word = '0;
      r_mask = '0; l_mask = '0;
      r_speed = '0; l_speed = '0; r_stamp = '0; l_stamp = '0;
      query_stamp = '0; ok_stamp = '0; timeouts = '0;
      recov_seen = '0; slot = '0; pending = 1'b0; fault = 1'b0;
      asked_index = wsfp_pkg::IDX_R_HIGH;
      node_cfg = '0;
      period_cfg = wsfp_pkg::PERIOD_RESET;
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (item_valid && item_ready) begin
        want = poll_event(item);
        if (item_typed) want = item_typed_res;
        speed_results.push_back(want);
        quiet_cycles = 0;
      end
      if (result_valid && result_ready) begin
        quiet_cycles = 0;
        if (speed_results.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", '0, '0);
        end else begin
          want = speed_results.pop_front();
          check_field("issue_query", 32'(result.issue_query), 32'(want.issue_query));
          check_field("query_index", 32'(result.query_index), 32'(want.query_index));
          check_field("query_node", 32'(result.query_node), 32'(want.query_node));
          check_field("right_wheel_rpm", result.right_wheel_rpm, want.right_wheel_rpm);
          check_field("left_wheel_rpm", result.left_wheel_rpm, want.left_wheel_rpm);
          check_field("right_live", 32'(result.right_live), 32'(want.right_live));
          check_field("left_live", 32'(result.left_live), 32'(want.left_live));
          check_field("right_age", result.right_age, want.right_age);
          check_field("left_age", result.left_age, want.left_age);
          check_field("fault_on", 32'(result.fault_on), 32'(want.fault_on));
          check_field("timeout_count", result.timeout_count, want.timeout_count);
          check_field("last_ok_age_ms", result.last_ok_age_ms, want.last_ok_age_ms);
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      result_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_beat(input wsfp_pkg::item_t e, input bit typed,
                           input wsfp_pkg::result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item = e;
    item_typed = typed;
    item_typed_res = want;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  task automatic cfg_access(input bit wr, input logic idx, input logic [31:0] value);
    logic [31:0] held;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      if (idx == wsfp_pkg::CFG_NODE_ID) node_cfg = value[10:0];
      else period_cfg = value[7:0];
    end else begin
      held = (idx == wsfp_pkg::CFG_NODE_ID) ? {21'd0, node_cfg} : {24'd0, period_cfg};
      check_field(idx == wsfp_pkg::CFG_NODE_ID ? "node_id read" : "query_period_ms read",
                  prdata, held);
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input logic [10:0] node,
                           input logic [7:0] period, input int count);
    wsfp_pkg::item_t e;
    int pick;
    int step_max;
    while (speed_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_access(1'b1, wsfp_pkg::CFG_NODE_ID, {21'd0, node});
    cfg_access(1'b0, wsfp_pkg::CFG_NODE_ID, '0);
    cfg_access(1'b1, wsfp_pkg::CFG_PERIOD, {24'd0, period});
    cfg_access(1'b0, wsfp_pkg::CFG_PERIOD, '0);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    step_max = (period > 8'd6) ? int'(period) / 3 : 2;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
      else if ($urandom_range(0, 79) == 0) clock_ms = '0;
      else clock_ms = clock_ms + $urandom_range(0, step_max);
      e = make_event(wsfp_pkg::REQ_TICK, clock_ms, '0, 16'($urandom),
                     4'($urandom_range(6, 8)), $urandom_range(0, 9) != 0, link_recoveries,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        e.req_type = wsfp_pkg::REQ_TICK;
      end else if (pick < 78) begin
        e.req_type = wsfp_pkg::REQ_RESP;
        if (pending && $urandom_range(0, 99) < 85) begin
          e.resp_index = asked_index;
        end else begin
          case ($urandom_range(0, 3))
            0: e.resp_index = wsfp_pkg::IDX_R_HIGH;
            1: e.resp_index = wsfp_pkg::IDX_R_LOW;
            2: e.resp_index = wsfp_pkg::IDX_L_HIGH;
            default: e.resp_index = wsfp_pkg::IDX_L_LOW;
          endcase
        end
        if ($urandom_range(0, 99) < 8) e.resp_index = 16'($urandom);
        if ($urandom_range(0, 9) == 0) e.resp_dlc = 4'($urandom_range(0, 15));
      end else if (pick < 83) begin
        e.req_type = wsfp_pkg::REQ_TIMEOUT;
      end else if (pick < 93) begin
        e.req_type = wsfp_pkg::REQ_BUS;
        if ($urandom_range(0, 99) < 30) link_recoveries = 16'($urandom);
        e.recov_count = link_recoveries;
      end else begin
        e = make_event(2'($urandom), $urandom, 16'($urandom), 16'($urandom), 4'($urandom),
                       1'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
      end
      send_beat(e, 1'b0, '0);
    end
    item_valid = 1'b0;
  endtask

  initial begin
    row_t rows[$];
    send_idle_pct = 30;
    recv_idle_pct = 71;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    rows.push_back('{make_event(wsfp_pkg::REQ_TICK, 32'd0, '0, '0, '0, 1'b1, '0, 1'b0, 1'b0),
                     1'b1,
                     no_speed_result(1'b1, wsfp_pkg::IDX_R_HIGH, '0, 1'b0, '0,
                                     wsfp_pkg::NONE_AGE)});
    rows.push_back('{make_event(wsfp_pkg::REQ_TICK, 32'd1, '0, '0, '0, 1'b1, '0, 1'b0, 1'b0),
                     1'b1,
                     no_speed_result(1'b0, '0, '0, 1'b0, '0, wsfp_pkg::NONE_AGE)});
    rows.push_back('{make_event(wsfp_pkg::REQ_RESP, 32'd0, wsfp_pkg::IDX_R_HIGH, 16'hFFFF,
                                4'd6, 1'b0, '0, 1'b0, 1'b0), 1'b1,
                     no_speed_result(1'b0, '0, '0, 1'b0, '0, wsfp_pkg::NONE_AGE)});
    rows.push_back('{make_event(wsfp_pkg::REQ_TICK, 32'd1, '0, '0, '0, 1'b1, '0, 1'b0, 1'b0),
                     1'b1,
                     no_speed_result(1'b1, wsfp_pkg::IDX_R_LOW, '0, 1'b0, '0,
                                     wsfp_pkg::NONE_AGE)});
    rows.push_back('{make_event(wsfp_pkg::REQ_RESP, 32'd2, wsfp_pkg::IDX_R_LOW, 16'h1234,
                                4'd5, 1'b1, '0, 1'b0, 1'b0), 1'b0, '0});
    rows.push_back('{make_event(wsfp_pkg::REQ_RESP, 32'd2, 16'h4016, 16'h5555, 4'd8, 1'b1,
                                '0, 1'b0, 1'b0), 1'b0, '0});
    rows.push_back('{make_event(wsfp_pkg::REQ_RESP, 32'd3, wsfp_pkg::IDX_R_LOW, 16'h0000,
                                4'd15, 1'b0, '0, 1'b0, 1'b0), 1'b0, '0});
    rows.push_back('{make_event(wsfp_pkg::REQ_TICK, 32'd3, '0, '0, '0, 1'b1, '0, 1'b0, 1'b0),
                     1'b0, '0});
    rows.push_back('{make_event(wsfp_pkg::REQ_TICK, 32'd6, '0, '0, '0, 1'b0, '0, 1'b0, 1'b0),
                     1'b0, '0});
    rows.push_back('{make_event(wsfp_pkg::REQ_TICK, 32'd6, '0, '0, '0, 1'b1, '0, 1'b0, 1'b0),
                     1'b0, '0});
    rows.push_back('{make_event(wsfp_pkg::REQ_RESP, 32'd7, wsfp_pkg::IDX_L_HIGH, 16'h7FFF,
                                4'd8, 1'b0, '0, 1'b0, 1'b0), 1'b0, '0});
    rows.push_back('{make_event(wsfp_pkg::REQ_TICK, 32'd11, '0, '0, '0, 1'b1, '0, 1'b0, 1'b0),
                     1'b0, '0});
    rows.push_back('{make_event(wsfp_pkg::REQ_RESP, 32'd12, wsfp_pkg::IDX_L_LOW, 16'hFFFF,
                                4'd6, 1'b0, '0, 1'b0, 1'b0), 1'b0, '0});
    rows.push_back('{make_event(wsfp_pkg::REQ_TIMEOUT, 32'd13, '0, '0, '0, 1'b0, '0, 1'b0,
                                1'b0), 1'b1,
                     no_speed_result(1'b0, '0, '0, 1'b1, 32'd1, 32'd1)});
    rows.push_back('{make_event(wsfp_pkg::REQ_TICK, 32'hFFFF_FFFF, '0, '0, '0, 1'b1, '0, 1'b0,
                                1'b0), 1'b0, '0});
    rows.push_back('{make_event(wsfp_pkg::REQ_BUS, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, '0, 1'b1,
                                1'b1), 1'b0, '0});
    rows.push_back('{make_event(wsfp_pkg::REQ_BUS, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, '0, 1'b1,
                                1'b0), 1'b0, '0});
    rows.push_back('{make_event(wsfp_pkg::REQ_TICK, 32'hFFFF_FFFF, '0, '0, '0, 1'b1, '0, 1'b0,
                                1'b0), 1'b0, '0});
    rows.push_back('{make_event(wsfp_pkg::REQ_BUS, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, 16'hFFFF,
                                1'b0, 1'b1), 1'b0, '0});
    rows.push_back('{make_event(wsfp_pkg::REQ_TICK, 32'd4, '0, '0, '0, 1'b1, 16'hFFFF, 1'b0,
                                1'b0), 1'b0, '0});
    rows.push_back('{make_event(wsfp_pkg::REQ_TIMEOUT, 32'd4, '0, '0, '0, 1'b1, 16'hFFFF, 1'b0,
                                1'b0), 1'b0, '0});
    rows.push_back('{make_event(wsfp_pkg::REQ_RESP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 4'hF,
                                1'b1, 16'hFFFF, 1'b1, 1'b1), 1'b0, '0});
    rows.push_back('{make_event(wsfp_pkg::REQ_RESP, 32'hFFFF_FFFF, wsfp_pkg::IDX_R_HIGH,
                                16'h8000, 4'd9, 1'b1, 16'hFFFF, 1'b1, 1'b1), 1'b0, '0});
    foreach (rows[i]) send_beat(rows[i].e, rows[i].typed, rows[i].want);
    item_valid = 1'b0;

    run_phase(30, 71, 11'h7FF, 8'd255, 400);
    run_phase(71, 30, 11'h000, 8'd1, 400);
    run_phase(0, 0, 11'($urandom), 8'd0, 400);
    run_phase(0, 0, 11'($urandom), 8'($urandom_range(1, 255)), 400);

    while (speed_results.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
